@@ src/rrfp_pkg.sv @@
// Shared types and constants for the radar report frame parser.
// No dependencies; every other file imports this package.
package rrfp_pkg;

	// Frame buffer size in bytes (23 to 127).
	localparam int FRAME_BYTES = 64;

	localparam int LEN_W   = 16;
	localparam int POS_W   = LEN_W + 1;
	localparam int TMO_W   = 16;
	localparam int FRAME_W = 7;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd100;

	localparam int FRAME_OVERHEAD = 10;
	localparam int TAIL_LEN       = 4;
	localparam logic [LEN_W-1:0] MIN_PAYLOAD = 16'd13;

	localparam logic [7:0] HDR_SEQ  [4] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
	localparam logic [7:0] TAIL_SEQ [4] = '{8'hF8, 8'hF7, 8'hF6, 8'hF5};
	localparam logic [7:0] HEAD_MARK = 8'hAA;
	localparam logic [7:0] END_MARK  = 8'h55;

	// Payload byte offsets of the captured report fields
	localparam logic [3:0] OFS_TYPE     = 4'd0;
	localparam logic [3:0] OFS_HEAD     = 4'd1;
	localparam logic [3:0] OFS_TSTATE   = 4'd2;
	localparam logic [3:0] OFS_MDIST_LO = 4'd3;
	localparam logic [3:0] OFS_MDIST_HI = 4'd4;
	localparam logic [3:0] OFS_MENERGY  = 4'd5;
	localparam logic [3:0] OFS_SDIST_LO = 4'd6;
	localparam logic [3:0] OFS_SDIST_HI = 4'd7;
	localparam logic [3:0] OFS_SENERGY  = 4'd8;
	localparam logic [3:0] OFS_DDIST_LO = 4'd9;
	localparam logic [3:0] OFS_DDIST_HI = 4'd10;

	localparam logic [7:0] TYPE_ENG   = 8'd1;
	localparam logic [7:0] TYPE_BASIC = 8'd2;

	localparam logic [7:0] TSTATE_MOVING = 8'd1;
	localparam logic [7:0] TSTATE_STATIC = 8'd2;
	localparam logic [7:0] TSTATE_BOTH   = 8'd3;

	localparam logic [1:0] PRES_NONE   = 2'd0;
	localparam logic [1:0] PRES_MOVING = 2'd1;
	localparam logic [1:0] PRES_STATIC = 2'd2;

	localparam logic [3:0] SPEED_MOVING_CMS = 4'd10;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_TIMEOUT    = 3'd1,
		ERR_OVERSIZE   = 3'd2,
		ERR_BAD_TAIL   = 3'd3,
		ERR_SHORT      = 3'd4,
		ERR_BAD_HEAD   = 3'd5,
		ERR_BAD_TYPE   = 3'd6,
		ERR_BAD_MARKER = 3'd7
	} err_t;

	// One classified input beat
	typedef struct packed {
		logic       is_tick;
		logic [7:0] data;
		logic [3:0] hdr_eq;
		logic [3:0] tail_eq;
	} item_class_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_stat_t;

	typedef struct packed {
		logic               ok;
		err_t               error_code;
		logic [7:0]         report_type;
		logic [1:0]         presence;
		logic [15:0]        target_range;
		logic [3:0]         target_speed;
		logic [7:0]         signal_level;
		logic [FRAME_W-1:0] frame_bytes;
	} result_t;

endpackage

@@ src/rrfp_if.sv @@
// Valid/ready channels for input beats and result beats.
// Depends on rrfp_pkg.
interface rrfp_item_if;
	import rrfp_pkg::*;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;
	modport source(output valid, output opcode, output rx_byte, input ready);
	modport sink(input valid, input opcode, input rx_byte, output ready);
endinterface

interface rrfp_result_if;
	import rrfp_pkg::*;
	logic               valid;
	logic               ready;
	logic               ok;
	logic [2:0]         error_code;
	logic [7:0]         report_type;
	logic [1:0]         presence;
	logic [15:0]        target_range;
	logic [3:0]         target_speed;
	logic [7:0]         signal_level;
	logic [FRAME_W-1:0] frame_bytes;
	modport source(output valid, output ok, output error_code, output report_type,
		output presence, output target_range, output target_speed, output signal_level,
		output frame_bytes, input ready);
	modport sink(input valid, input ok, input error_code, input report_type,
		input presence, input target_range, input target_speed, input signal_level,
		input frame_bytes, output ready);
endinterface

@@ src/radar_report_frame_parser.sv @@
// Top level of the radar report frame parser: front end, beat queue and frame engine.
// Depends on rrfp_pkg, rrfp_if, rrfp_front, rrfp_queue and rrfp_back.
//
// Each input beat is either one received serial byte (opcode 0) or one millisecond
// tick (opcode 1). The parser hunts for the header F4 F3 F2 F1, reads a little-endian
// payload length, captures the report fields as the payload passes and checks the
// tail F8 F7 F6 F5. A frame with a good tail yields one result beat: either the parsed
// report (ok = 1) or an error code; a too-large frame is drained and reported as
// oversize. Every attempt must complete within the configured number of ticks, or a
// timeout result is given and the hunt restarts. The tick count is written through
// cfg_we/cfg_wdata (reset value 100); the user must write it only while the block is
// idle, as the block does not enforce this. Most beats give no result. Throughput is
// one beat per clock in both directions while results are taken. An accepted beat
// goes into a two-entry queue; the frame engine takes it from the queue head and
// registers any result in the output register that drives result valid. The engine
// only stalls when the output register is full and not being taken; the queue then
// fills and item.ready drops. There is no memory and no clearing pass after reset.
module radar_report_frame_parser (
	input  logic          clk,
	input  logic          arst_n,
	rrfp_item_if.sink     item,
	rrfp_result_if.source result,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata
);
	import rrfp_pkg::*;

	queue_stat_t q_stat;
	item_class_t push_entry;
	item_class_t q_head;
	logic        push;
	logic        pop;

	// Classify each byte against header and tail patterns on the way in
	rrfp_front u_front (
		.item       (item),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouples input acceptance from result back-pressure
	rrfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (q_head),
		.q_stat     (q_stat)
	);

	// Frame state machine, timeout timer and registered result
	rrfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (q_head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

endmodule

@@ src/rrfp_front.sv @@
// Front end: accepts input beats and classifies them against the header and tail bytes.
// Depends on rrfp_pkg and rrfp_if.
module rrfp_front (
	rrfp_item_if.sink            item,
	input  rrfp_pkg::queue_stat_t q_stat,
	output logic                 push,
	output rrfp_pkg::item_class_t push_entry
);
	import rrfp_pkg::*;

	assign item.ready = !q_stat.full;
	assign push       = item.valid && !q_stat.full;

	always_comb begin
		push_entry.is_tick = item.opcode;
		push_entry.data    = item.rx_byte;
		for (int i = 0; i < 4; i++) begin
			push_entry.hdr_eq[i]  = (item.rx_byte == HDR_SEQ[i]);
			push_entry.tail_eq[i] = (item.rx_byte == TAIL_SEQ[i]);
		end
	end

endmodule

@@ src/rrfp_queue.sv @@
// Short FIFO of classified beats between the front end and the frame engine.
// Depends on rrfp_pkg.
module rrfp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rrfp_pkg::item_class_t push_entry,
	input  logic                  pop,
	output rrfp_pkg::item_class_t head,
	output rrfp_pkg::queue_stat_t q_stat
);
	import rrfp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_class_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign q_stat.full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_stat.not_empty = (count_q != '0);
	assign head             = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/rrfp_back.sv @@
// Frame engine: header hunt, length, payload capture, tail check, validation and timeout.
// Depends on rrfp_pkg and rrfp_if; drives the registered result beat.
module rrfp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rrfp_pkg::queue_stat_t q_stat,
	input  rrfp_pkg::item_class_t head,
	output logic                  pop,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	rrfp_result_if.source         result
);
	import rrfp_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD,
		PH_TAIL,
		PH_DRAIN
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [1:0]         match_q, match_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [TMO_W-1:0]   elapsed_q, elapsed_d;
	logic [TMO_W-1:0]   timeout_q;
	logic [7:0]         type_q, head_q, tstate_q, menergy_q, senergy_q, marker_q;
	logic [15:0]        mdist_q, sdist_q, ddist_q;
	logic               res_valid_q;
	result_t            res_q;

	logic [TMO_W-1:0]   el_inc;
	logic [POS_W-1:0]   pos_inc;
	logic [POS_W-1:0]   len_hi_sum;
	logic [LEN_W-1:0]   len_hi_val;
	logic               fire, restart, cap_en, marker_hit;
	result_t            res_d, fin_res;

	assign pop     = q_stat.not_empty && (!res_valid_q || result.ready);
	assign el_inc  = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign pos_inc = pos_q + 1'b1;

	assign len_hi_val = {head.data, len_q[7:0]};
	assign len_hi_sum = {1'b0, len_hi_val} + POS_W'(FRAME_OVERHEAD);

	assign cap_en     = (phase_q == PH_PAYLOAD) && (pos_q[POS_W-1:4] == '0);
	assign marker_hit = (len_q >= 16'd2) && (pos_q == {1'b0, len_q - 16'd2});

	// Validation of a frame whose tail was good
	always_comb begin
		fin_res = '0;
		if (len_q < MIN_PAYLOAD) begin
			fin_res.error_code = ERR_SHORT;
		end else if (head_q != HEAD_MARK) begin
			fin_res.error_code = ERR_BAD_HEAD;
		end else if (type_q != TYPE_ENG && type_q != TYPE_BASIC) begin
			fin_res.error_code = ERR_BAD_TYPE;
		end else if (marker_q != END_MARK) begin
			fin_res.error_code = ERR_BAD_MARKER;
		end else begin
			fin_res.ok          = 1'b1;
			fin_res.error_code  = ERR_NONE;
			fin_res.report_type = type_q;
			if (tstate_q == TSTATE_MOVING || tstate_q == TSTATE_BOTH) begin
				fin_res.presence     = PRES_MOVING;
				fin_res.target_speed = SPEED_MOVING_CMS;
			end else if (tstate_q == TSTATE_STATIC) begin
				fin_res.presence = PRES_STATIC;
			end else begin
				fin_res.presence = PRES_NONE;
			end
			if (ddist_q != '0) begin
				fin_res.target_range = ddist_q;
			end else if (mdist_q != '0) begin
				fin_res.target_range = mdist_q;
			end else begin
				fin_res.target_range = sdist_q;
			end
			fin_res.signal_level = (menergy_q > senergy_q) ? menergy_q : senergy_q;
			fin_res.frame_bytes  = FRAME_W'(len_q + LEN_W'(FRAME_OVERHEAD));
		end
	end

	// Next state for the beat at the queue head
	always_comb begin
		phase_d   = phase_q;
		match_d   = match_q;
		len_d     = len_q;
		pos_d     = pos_q;
		elapsed_d = elapsed_q;
		fire      = 1'b0;
		restart   = 1'b0;
		res_d     = '0;
		if (head.is_tick) begin
			elapsed_d = el_inc;
			if (el_inc >= timeout_q) begin
				fire             = 1'b1;
				restart          = 1'b1;
				res_d.error_code = ERR_TIMEOUT;
			end
		end else if (elapsed_q >= timeout_q) begin
			fire             = 1'b1;
			restart          = 1'b1;
			res_d.error_code = ERR_TIMEOUT;
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (head.hdr_eq[match_q]) begin
						match_d = match_q + 1'b1;
						if (match_q == 2'd3) begin
							phase_d = PH_LEN_LO;
						end
					end else begin
						match_d = {1'b0, head.hdr_eq[0]};
					end
				end
				PH_LEN_LO: begin
					len_d   = {8'h00, head.data};
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_d = len_hi_val;
					pos_d = '0;
					if (len_hi_sum > POS_W'(FRAME_BYTES)) begin
						phase_d = PH_DRAIN;
					end else if (len_hi_val == '0) begin
						phase_d = PH_TAIL;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					pos_d = pos_inc;
					if (pos_inc >= {1'b0, len_q}) begin
						pos_d   = '0;
						phase_d = PH_TAIL;
					end
				end
				PH_TAIL: begin
					pos_d = pos_inc;
					if (!head.tail_eq[pos_q[1:0]]) begin
						fire             = 1'b1;
						restart          = 1'b1;
						res_d.error_code = ERR_BAD_TAIL;
					end else if (pos_inc >= POS_W'(TAIL_LEN)) begin
						fire    = 1'b1;
						restart = 1'b1;
						res_d   = fin_res;
					end
				end
				PH_DRAIN: begin
					pos_d = pos_inc;
					if (pos_inc >= {1'b0, len_q} + POS_W'(TAIL_LEN)) begin
						fire             = 1'b1;
						restart          = 1'b1;
						res_d.error_code = ERR_OVERSIZE;
					end
				end
				default: begin
					restart = 1'b1;
				end
			endcase
		end
		if (restart) begin
			phase_d   = PH_HUNT;
			match_d   = '0;
			pos_d     = '0;
			elapsed_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			match_q     <= '0;
			len_q       <= '0;
			pos_q       <= '0;
			elapsed_q   <= '0;
			timeout_q   <= TIMEOUT_RESET;
			type_q      <= '0;
			head_q      <= '0;
			tstate_q    <= '0;
			mdist_q     <= '0;
			menergy_q   <= '0;
			sdist_q     <= '0;
			senergy_q   <= '0;
			ddist_q     <= '0;
			marker_q    <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (pop) begin
				phase_q   <= phase_d;
				match_q   <= match_d;
				len_q     <= len_d;
				pos_q     <= pos_d;
				elapsed_q <= elapsed_d;
				if (!head.is_tick && (elapsed_q < timeout_q) && cap_en) begin
					case (pos_q[3:0])
						OFS_TYPE:     type_q         <= head.data;
						OFS_HEAD:     head_q         <= head.data;
						OFS_TSTATE:   tstate_q       <= head.data;
						OFS_MDIST_LO: mdist_q[7:0]   <= head.data;
						OFS_MDIST_HI: mdist_q[15:8]  <= head.data;
						OFS_MENERGY:  menergy_q      <= head.data;
						OFS_SDIST_LO: sdist_q[7:0]   <= head.data;
						OFS_SDIST_HI: sdist_q[15:8]  <= head.data;
						OFS_SENERGY:  senergy_q      <= head.data;
						OFS_DDIST_LO: ddist_q[7:0]   <= head.data;
						OFS_DDIST_HI: ddist_q[15:8]  <= head.data;
						default:      ;
					endcase
				end
				if (!head.is_tick && (elapsed_q < timeout_q)
						&& (phase_q == PH_PAYLOAD) && marker_hit) begin
					marker_q <= head.data;
				end
			end
			if (pop && fire) begin
				res_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid        = res_valid_q;
	assign result.ok           = res_q.ok;
	assign result.error_code   = res_q.error_code;
	assign result.report_type  = res_q.report_type;
	assign result.presence     = res_q.presence;
	assign result.target_range = res_q.target_range;
	assign result.target_speed = res_q.target_speed;
	assign result.signal_level = res_q.signal_level;
	assign result.frame_bytes  = res_q.frame_bytes;

endmodule

@@ src/rrfp_checker.sv @@
// Port-level checks on the result channel of the radar report frame parser.
// Depends on rrfp_pkg; bound to radar_report_frame_parser below.
module rrfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic        ok,
	input logic [2:0]  error_code,
	input logic [7:0]  report_type,
	input logic [1:0]  presence,
	input logic [15:0] target_range,
	input logic [3:0]  target_speed,
	input logic [7:0]  signal_level,
	input logic [6:0]  frame_bytes
);
	import rrfp_pkg::*;

	// A stalled result beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable({ok, error_code, report_type, presence,
			target_range, target_speed, signal_level, frame_bytes}))
		else $error("result beat changed while stalled");

	// A good report carries no error, a known type and a valid presence
	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ok |-> error_code == ERR_NONE
			&& (report_type == TYPE_ENG || report_type == TYPE_BASIC)
			&& presence != 2'd3)
		else $error("malformed good report");

	// Speed follows presence
	a_speed: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ok |-> (presence == PRES_MOVING) ? (target_speed == SPEED_MOVING_CMS)
			: (target_speed == 4'd0))
		else $error("speed does not match presence");

	// Error beats carry a code and nothing else
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ok |-> error_code != ERR_NONE && report_type == 8'd0
			&& presence == 2'd0 && target_range == 16'd0 && target_speed == 4'd0
			&& signal_level == 8'd0 && frame_bytes == 7'd0)
		else $error("error beat with report fields set");

endmodule

bind radar_report_frame_parser rrfp_checker u_rrfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (result.valid),
	.ready        (result.ready),
	.ok           (result.ok),
	.error_code   (result.error_code),
	.report_type  (result.report_type),
	.presence     (result.presence),
	.target_range (result.target_range),
	.target_speed (result.target_speed),
	.signal_level (result.signal_level),
	.frame_bytes  (result.frame_bytes)
);
